// File: sv/msvr_pkg.sv
// Package for the mesh subset vertex remap block.
// Holds field widths, command and UV mode codes, default sizes and the
// structs exchanged between the top level and the table unit. No dependencies.
package msvr_pkg;

  // Field widths of the channels and the register
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned FACE_W      = 12;
  localparam int unsigned VTX_W       = 12;
  localparam int unsigned FSIZE_W     = 8;
  localparam int unsigned UV_SLOT_W   = 16;
  localparam int unsigned UV_MODE_W   = 2;

  // Index space reachable through the 12-bit face and vertex fields
  localparam int unsigned ADDR_SPACE  = 4096;

  // Default sizes
  localparam int unsigned DEF_MAX_VERTICES = 4096;
  localparam int unsigned DEF_MAX_FACES    = 4096;
  localparam int unsigned DEF_CURSOR_BITS  = 16;

  // Commands
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MARK   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_VERTEX = 2'd2;

  // UV modes (the unused code behaves as UV_NONE)
  localparam logic [UV_MODE_W-1:0] UV_NONE   = 2'd0;
  localparam logic [UV_MODE_W-1:0] UV_FACE   = 2'd1;
  localparam logic [UV_MODE_W-1:0] UV_VERTEX = 2'd2;

  // Table depth actually needed: never more than the field can address
  function automatic int unsigned clamp_depth(input int unsigned max_entries);
    clamp_depth = (max_entries < ADDR_SPACE) ? max_entries : ADDR_SPACE;
  endfunction

  // Read / mark / clear request to the table unit
  typedef struct packed {
    logic              rd_en;
    logic              mark_en;
    logic              clear_start;
    logic [FACE_W-1:0] face_id;
    logic [VTX_W-1:0]  vertex_index;
  } tbl_req_t;

  // Remap entry write from the result stage
  typedef struct packed {
    logic             wr_en;
    logic [VTX_W-1:0] vertex_index;
    logic [VTX_W-1:0] new_index;
  } tbl_wr_t;

  // Registered read results and sweep status
  typedef struct packed {
    logic             sweeping;
    logic             member;
    logic             vtx_valid;
    logic [VTX_W-1:0] vtx_index;
  } tbl_rsp_t;

endpackage

// File: sv/msvr_if.sv
// Channel interfaces of the mesh subset vertex remap block.
// Valid/ready handshake plus payload; field widths from msvr_pkg.
interface msvr_in_if;
  logic                         valid;
  logic                         ready;
  logic [msvr_pkg::CMD_W-1:0]   cmd;
  logic [msvr_pkg::FACE_W-1:0]  face_id;
  logic [msvr_pkg::VTX_W-1:0]   vertex_index;
  logic [msvr_pkg::FSIZE_W-1:0] face_size;
  logic                         first_corner;

  modport source (output valid, cmd, face_id, vertex_index, face_size, first_corner,
                  input ready);
  modport sink   (input valid, cmd, face_id, vertex_index, face_size, first_corner,
                  output ready);
endinterface

interface msvr_out_if;
  logic                           valid;
  logic                           ready;
  logic [msvr_pkg::VTX_W-1:0]     new_index;
  logic                           new_point;
  logic [msvr_pkg::VTX_W-1:0]     old_vertex;
  logic                           face_start;
  logic [msvr_pkg::FSIZE_W-1:0]   face_count;
  logic                           uv_emit;
  logic [msvr_pkg::UV_SLOT_W-1:0] uv_slot;
  logic                           overflow;

  modport source (output valid, new_index, new_point, old_vertex, face_start, face_count,
                  uv_emit, uv_slot, overflow,
                  input ready);
  modport sink   (input valid, new_index, new_point, old_vertex, face_start, face_count,
                  uv_emit, uv_slot, overflow,
                  output ready);
endinterface

// File: sv/msvr_tables.sv
// Face membership and vertex remap memories with clearing sweep and
// write-to-read forwarding. Uses msvr_pkg structs and constants.
module msvr_tables #(
  parameter int unsigned MAX_VERTICES = msvr_pkg::DEF_MAX_VERTICES,
  parameter int unsigned MAX_FACES    = msvr_pkg::DEF_MAX_FACES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  msvr_pkg::tbl_req_t req,
  input  msvr_pkg::tbl_wr_t  wr,
  output msvr_pkg::tbl_rsp_t rsp
);

  localparam int unsigned VTX_DEPTH  = msvr_pkg::clamp_depth(MAX_VERTICES);
  localparam int unsigned FACE_DEPTH = msvr_pkg::clamp_depth(MAX_FACES);
  localparam int unsigned VA_W       = $clog2(VTX_DEPTH);
  localparam int unsigned FA_W       = $clog2(FACE_DEPTH);
  localparam int unsigned VTX_MEM    = 1 << VA_W;
  localparam int unsigned FACE_MEM   = 1 << FA_W;
  localparam int unsigned SW_W       = (VA_W > FA_W) ? VA_W : FA_W;

  // Remap entry: valid flag over the compacted index
  logic [VA_W:0] vtx_mem  [0:VTX_MEM-1];
  logic          face_mem [0:FACE_MEM-1];

  logic [VA_W:0]            vtx_q_r;
  logic                     face_q_r;
  logic                     fwd_hit_r;
  logic [VA_W-1:0]          fwd_idx_r;
  logic                     sweep_r;
  logic [SW_W-1:0]          sweep_cnt_r;
  logic [VA_W-1:0]          rd_vaddr;
  logic [FA_W-1:0]          rd_faddr;
  logic [VA_W-1:0]          wr_vaddr;
  logic [VA_W-1:0]          wr_idx;

  assign rd_vaddr = req.vertex_index[VA_W-1:0];
  assign rd_faddr = req.face_id[FA_W-1:0];
  assign wr_vaddr = wr.vertex_index[VA_W-1:0];
  assign wr_idx   = wr.new_index[VA_W-1:0];

  // Clearing sweep: after reset and after every clear command
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r     <= 1'b1;
      sweep_cnt_r <= '0;
    end else if (req.clear_start) begin
      sweep_r     <= 1'b1;
      sweep_cnt_r <= '0;
    end else if (sweep_r) begin
      sweep_cnt_r <= sweep_cnt_r + 1'b1;
      if (sweep_cnt_r == '1) begin
        sweep_r <= 1'b0;
      end
    end
  end

  // Face membership memory
  always_ff @(posedge clk) begin
    if (sweep_r) begin
      face_mem[sweep_cnt_r[FA_W-1:0]] <= 1'b0;
    end else if (req.mark_en) begin
      face_mem[rd_faddr] <= 1'b1;
    end
    if (req.rd_en) begin
      face_q_r <= face_mem[rd_faddr];
    end
  end

  // Vertex remap memory
  always_ff @(posedge clk) begin
    if (sweep_r) begin
      vtx_mem[sweep_cnt_r[VA_W-1:0]] <= '0;
    end else if (wr.wr_en) begin
      vtx_mem[wr_vaddr] <= {1'b1, wr_idx};
    end
    if (req.rd_en) begin
      vtx_q_r   <= vtx_mem[rd_vaddr];
      fwd_idx_r <= wr_idx;
    end
  end

  // A write landing on the edge of the read is not seen by the memory read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (req.rd_en) begin
      fwd_hit_r <= wr.wr_en && (wr.vertex_index == req.vertex_index);
    end
  end

  always_comb begin
    rsp.sweeping  = sweep_r;
    rsp.member    = face_q_r;
    rsp.vtx_valid = fwd_hit_r | vtx_q_r[VA_W];
    rsp.vtx_index = fwd_hit_r ? msvr_pkg::VTX_W'(fwd_idx_r)
                              : msvr_pkg::VTX_W'(vtx_q_r[VA_W-1:0]);
  end

endmodule

// File: sv/mesh_subset_vertex_remap.sv
// Top level of the mesh subset vertex remap block.
// Depends on msvr_pkg, the channel interfaces in msvr_if.sv and msvr_tables.
//
// Usage:
//   in_ch carries commands: clear (start a new subset), mark (face is a
//   member) and face vertex. out_ch gives one result per face vertex of a
//   member face: compacted index, first-sight flag, face size on the first
//   corner, UV slot and overflow. cfg_wr_en / cfg_wr_data write uv_mode.
// Timing:
//   A face vertex is accepted with its table reads, which are registered
//   alongside it in the read stage; its result then moves to the output
//   register. One transaction per cycle is sustained while no sweep runs and
//   the output does not stall; a remap write is forwarded to the item read
//   on the same edge. The item rate is set by the remap read-modify-write.
//   A clear takes one transaction and then a sweep over the larger of the
//   two table address spaces, during which in_ch.ready is low.
// Reset:
//   rst_n clears counters and uv_mode and starts the same sweep.
// Stalls:
//   When out_ch.ready is low the result holds in the output register; one
//   more item of a member face waits in the read stage and in_ch.ready then drops.
module mesh_subset_vertex_remap #(
  parameter int unsigned MAX_VERTICES = msvr_pkg::DEF_MAX_VERTICES,
  parameter int unsigned MAX_FACES    = msvr_pkg::DEF_MAX_FACES,
  parameter int unsigned CURSOR_BITS  = msvr_pkg::DEF_CURSOR_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  msvr_in_if.sink                          in_ch,
  msvr_out_if.source                       out_ch,
  input  logic                             cfg_wr_en,
  input  logic [msvr_pkg::UV_MODE_W-1:0]   cfg_wr_data
);

  localparam int unsigned VTX_DEPTH  = msvr_pkg::clamp_depth(MAX_VERTICES);
  localparam int unsigned FACE_DEPTH = msvr_pkg::clamp_depth(MAX_FACES);
  localparam int unsigned NI_W       = $clog2(VTX_DEPTH + 1);

  msvr_pkg::tbl_req_t tbl_req;
  msvr_pkg::tbl_wr_t  tbl_wr;
  msvr_pkg::tbl_rsp_t tbl_rsp;

  logic [msvr_pkg::UV_MODE_W-1:0] uv_mode_r;
  logic [NI_W-1:0]                next_index_r;
  logic [CURSOR_BITS-1:0]         cursor_r;

  // Read stage
  logic                           s1_valid_r;
  logic                           s1_face_ok_r;
  logic                           s1_vtx_ok_r;
  logic                           s1_sat_r;
  logic [CURSOR_BITS-1:0]         s1_cur_r;
  logic [msvr_pkg::VTX_W-1:0]     s1_vtx_r;
  logic [msvr_pkg::FSIZE_W-1:0]   s1_fsize_r;
  logic                           s1_first_r;

  // Output register
  logic                           out_valid_r;
  logic [msvr_pkg::VTX_W-1:0]     out_new_index_r;
  logic                           out_new_point_r;
  logic [msvr_pkg::VTX_W-1:0]     out_old_vertex_r;
  logic                           out_face_start_r;
  logic [msvr_pkg::FSIZE_W-1:0]   out_face_count_r;
  logic                           out_uv_emit_r;
  logic [msvr_pkg::UV_SLOT_W-1:0] out_uv_slot_r;
  logic                           out_overflow_r;

  logic                           accept;
  logic                           is_clear;
  logic                           is_mark;
  logic                           is_vertex;
  logic                           face_ok;
  logic                           vtx_ok;
  logic                           out_free;
  logic                           s1_result;
  logic                           s1_go;
  logic                           member;
  logic                           hit;
  logic                           full;
  logic                           fresh;
  logic                           ovf;
  logic                           commit;
  logic [12:0]                    ni_ext;
  logic [31:0]                    cur_ext;
  logic [msvr_pkg::VTX_W-1:0]     idx;
  logic                           emit;
  logic [msvr_pkg::UV_SLOT_W-1:0] slot;

  // Input decode and handshake
  always_comb begin
    is_clear  = (in_ch.cmd == msvr_pkg::CMD_CLEAR);
    is_mark   = (in_ch.cmd == msvr_pkg::CMD_MARK);
    is_vertex = (in_ch.cmd == msvr_pkg::CMD_VERTEX);
    face_ok   = {1'b0, in_ch.face_id} < 13'(FACE_DEPTH);
    vtx_ok    = {1'b0, in_ch.vertex_index} < 13'(VTX_DEPTH);
    out_free  = !out_valid_r || out_ch.ready;
    s1_result = s1_valid_r && member;
    s1_go     = !s1_result || out_free;
  end

  assign in_ch.ready = !tbl_rsp.sweeping && (!s1_valid_r || s1_go);
  assign accept      = in_ch.valid && in_ch.ready;

  // Table requests
  always_comb begin
    tbl_req.rd_en        = accept && is_vertex;
    tbl_req.mark_en      = accept && is_mark && face_ok;
    tbl_req.clear_start  = accept && is_clear;
    tbl_req.face_id      = in_ch.face_id;
    tbl_req.vertex_index = in_ch.vertex_index;
  end

  msvr_tables #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_FACES    (MAX_FACES)
  ) u_tables (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (tbl_req),
    .wr    (tbl_wr),
    .rsp   (tbl_rsp)
  );

  // Result stage: remap lookup, first-sight assignment and UV slot
  always_comb begin
    member  = s1_face_ok_r && tbl_rsp.member;
    hit     = tbl_rsp.vtx_valid;
    full    = (next_index_r == NI_W'(VTX_DEPTH));
    fresh   = s1_vtx_ok_r && !hit && !full;
    ovf     = s1_sat_r || !s1_vtx_ok_r || (!hit && full);
    ni_ext  = 13'(next_index_r);
    cur_ext = 32'(s1_cur_r);
    if (s1_vtx_ok_r && hit) begin
      idx = tbl_rsp.vtx_index;
    end else if (fresh) begin
      idx = ni_ext[11:0];
    end else begin
      idx = '0;
    end
    case (uv_mode_r)
      msvr_pkg::UV_FACE: begin
        emit = 1'b1;
        slot = cur_ext[15:0];
      end
      msvr_pkg::UV_VERTEX: begin
        emit = fresh;
        slot = fresh ? msvr_pkg::UV_SLOT_W'(s1_vtx_r) : '0;
      end
      default: begin
        emit = 1'b0;
        slot = '0;
      end
    endcase
    commit = s1_result && s1_go && fresh;
  end

  always_comb begin
    tbl_wr.wr_en        = commit;
    tbl_wr.vertex_index = s1_vtx_r;
    tbl_wr.new_index    = ni_ext[11:0];
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      uv_mode_r <= msvr_pkg::UV_NONE;
    end else if (cfg_wr_en) begin
      uv_mode_r <= cfg_wr_data;
    end
  end

  // Vertex and corner counters; a clear wins over a commit on the same edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_index_r <= '0;
      cursor_r     <= '0;
    end else if (accept && is_clear) begin
      next_index_r <= '0;
      cursor_r     <= '0;
    end else begin
      if (commit) begin
        next_index_r <= next_index_r + 1'b1;
      end
      if (accept && is_vertex && (cursor_r != '1)) begin
        cursor_r <= cursor_r + 1'b1;
      end
    end
  end

  // Read stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= is_vertex;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Read stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_face_ok_r <= face_ok;
      s1_vtx_ok_r  <= vtx_ok;
      s1_sat_r     <= (cursor_r == '1);
      s1_cur_r     <= cursor_r;
      s1_vtx_r     <= in_ch.vertex_index;
      s1_fsize_r   <= in_ch.face_size;
      s1_first_r   <= in_ch.first_corner;
    end
  end

  // Output register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_result && s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (s1_result && s1_go) begin
      out_new_index_r  <= idx;
      out_new_point_r  <= fresh;
      out_old_vertex_r <= s1_vtx_r;
      out_face_start_r <= s1_first_r;
      out_face_count_r <= s1_first_r ? s1_fsize_r : '0;
      out_uv_emit_r    <= emit;
      out_uv_slot_r    <= slot;
      out_overflow_r   <= ovf;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.new_index  = out_new_index_r;
  assign out_ch.new_point  = out_new_point_r;
  assign out_ch.old_vertex = out_old_vertex_r;
  assign out_ch.face_start = out_face_start_r;
  assign out_ch.face_count = out_face_count_r;
  assign out_ch.uv_emit    = out_uv_emit_r;
  assign out_ch.uv_slot    = out_uv_slot_r;
  assign out_ch.overflow   = out_overflow_r;

endmodule
